/* rtl/curve_closest_point_query_core_macros.svh */
// Assertion macros shared by the curve query RTL
`ifndef CURVE_CLOSEST_POINT_QUERY_CORE_MACROS_SVH
`define CURVE_CLOSEST_POINT_QUERY_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CCPQ_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication
`define CCPQ_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/ccpq_pkg.sv */
// ----------------------------------------------------------------------------
// ccpq_pkg
// Types and constants for the curve closest-point query core.
// ----------------------------------------------------------------------------
package ccpq_pkg;
    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int PARAM_W   = FRAC_W + 1;
    localparam int SAMPLES   = 100;
    localparam int CNT_W     = $clog2(SAMPLES + 1);
    localparam int DIST_W    = 2 * COORD_W + 2;

    // Sample spacing ONE/SAMPLES as quotient and remainder, plus the rounding offset
    localparam int STEP_Q    = (1 << FRAC_W) / SAMPLES;
    localparam int STEP_R    = (1 << FRAC_W) % SAMPLES;
    localparam int HALF_S    = SAMPLES / 2;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CUBIC = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [PARAM_W-1:0] param_t;

    // One de Casteljau lerp with rounding; result stays between a and b
    function automatic coord_t lerp(input coord_t a, input coord_t b, input param_t t);
        logic signed [COORD_W:0]           d;
        logic signed [COORD_W+PARAM_W+1:0] p;
        begin
            d = COORD_W'(0) + ($signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a}));
            p = d * $signed({1'b0, t}) + (COORD_W+PARAM_W+2)'(1 << (FRAC_W - 1));
            lerp = COORD_W'($signed({a[COORD_W-1], a}) + p[COORD_W+FRAC_W:FRAC_W]);
        end
    endfunction
endpackage

/* rtl/curve_closest_point_query_core.sv */
// ----------------------------------------------------------------------------
// curve_closest_point_query_core
// Nearest parameter and point on a point, line segment or cubic Bezier.
// ----------------------------------------------------------------------------
// A cubic request occupies the input while its SAMPLES+1 (101) samples issue:
// one sample enters the pipeline per cycle while the pipe is not stalled, and a
// running minimum keeps the best one, so the next request is taken only after
// the last sample of a cubic. Point, line and invalid requests can follow back
// to back. Every request, whatever its kind, passes the same pipe: line setup,
// a 16-stage radix-2 divider for the line parameter, three lerp levels, the
// distance stage and the result register. Results leave in request order; any
// cycle with a result waiting under out_stall freezes the whole pipe and stalls
// the input.
module curve_closest_point_query_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        curve_kind,
    input  logic signed [ccpq_pkg::COORD_W-1:0] first_x,
    input  logic signed [ccpq_pkg::COORD_W-1:0] first_y,
    input  logic signed [ccpq_pkg::COORD_W-1:0] second_x,
    input  logic signed [ccpq_pkg::COORD_W-1:0] second_y,
    input  logic signed [ccpq_pkg::COORD_W-1:0] third_x,
    input  logic signed [ccpq_pkg::COORD_W-1:0] third_y,
    input  logic signed [ccpq_pkg::COORD_W-1:0] fourth_x,
    input  logic signed [ccpq_pkg::COORD_W-1:0] fourth_y,
    input  logic signed [ccpq_pkg::COORD_W-1:0] ref_x,
    input  logic signed [ccpq_pkg::COORD_W-1:0] ref_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ccpq_pkg::PARAM_W-1:0]      best_param,
    output logic signed [ccpq_pkg::COORD_W-1:0] near_x,
    output logic signed [ccpq_pkg::COORD_W-1:0] near_y
);
`include "curve_closest_point_query_core_macros.svh"

    localparam int CW = ccpq_pkg::COORD_W;
    localparam int FW = ccpq_pkg::FRAC_W;
    localparam int PW = ccpq_pkg::PARAM_W;
    localparam int NW = CW;
    localparam int SW = ccpq_pkg::CNT_W;
    localparam int DW = ccpq_pkg::DIST_W;
    localparam int NQ = 2 * CW + 3;      // dot product width
    localparam int DV = 2 * CW + 3;      // divider remainder width

    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [1:0]         kind;
        logic [PW-1:0]      t;
        logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, rx, ry;
        logic [DV-1:0]      rem;
        logic [DV-1:0]      den;
        logic [FW-1:0]      q;
        logic               sat_zero;
        logic               sat_one;
    } stg_t;

    // pipeline stall: whole pipe freezes while the output register is full and out_stall is high
    logic adv;
    assign adv = !out_valid || !out_stall;

    // ------------------------------------------------------------------
    // Issue sequencer: holds one request and walks its samples
    // ------------------------------------------------------------------
    logic                 busy_reg, busy_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        st_reg, st_next;
    logic [SW-1:0]        frac_reg, frac_next;
    logic [PW-1:0]        st_base, st_step;
    logic [SW-1:0]        frac_base, frac_step;
    logic [SW:0]          frac_sum;
    stg_t                 hold_reg, hold_next;
    stg_t                 iss;

    logic take;
    assign in_stall = !adv || busy_reg;
    assign take     = in_valid && !in_stall;

    // sample parameter walk: t steps by ONE/SAMPLES, remainder carried exactly
    always_comb
    begin
        st_base   = take ? '0 : st_reg;
        frac_base = take ? SW'(ccpq_pkg::HALF_S) : frac_reg;
        frac_sum  = {1'b0, frac_base} + (SW+1)'(ccpq_pkg::STEP_R);
        if (frac_sum >= (SW+1)'(ccpq_pkg::SAMPLES))
        begin
            st_step   = st_base + PW'(ccpq_pkg::STEP_Q + 1);
            frac_step = SW'(frac_sum - (SW+1)'(ccpq_pkg::SAMPLES));
        end
        else
        begin
            st_step   = st_base + PW'(ccpq_pkg::STEP_Q);
            frac_step = SW'(frac_sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        st_next   = st_reg;
        frac_next = frac_reg;
        hold_next = hold_reg;
        if (take)
        begin
            hold_next = '0;
            hold_next.kind = curve_kind;
            hold_next.p0x = first_x;  hold_next.p0y = first_y;
            hold_next.p1x = second_x; hold_next.p1y = second_y;
            hold_next.p2x = third_x;  hold_next.p2y = third_y;
            hold_next.p3x = fourth_x; hold_next.p3y = fourth_y;
            hold_next.rx  = ref_x;    hold_next.ry  = ref_y;
            busy_next = (curve_kind == ccpq_pkg::KIND_CUBIC);
            idx_next  = SW'(1);
            st_next   = st_step;
            frac_next = frac_step;
        end
        else if (adv && busy_reg)
        begin
            if (idx_reg == SW'(ccpq_pkg::SAMPLES))
                busy_next = 1'b0;
            idx_next  = idx_reg + 1'b1;
            st_next   = st_step;
            frac_next = frac_step;
        end
    end

    // issue word: new request at sample 0, or the held cubic at later samples
    always_comb
    begin
        iss = hold_reg;
        iss.vld = 1'b0;
        if (take)
        begin
            iss = hold_next;
            iss.vld   = 1'b1;
            iss.first = 1'b1;
            iss.last  = (curve_kind != ccpq_pkg::KIND_CUBIC);
            iss.t     = '0;
        end
        else if (busy_reg)
        begin
            iss.vld   = 1'b1;
            iss.first = 1'b0;
            iss.last  = (idx_reg == SW'(ccpq_pkg::SAMPLES));
            iss.t     = st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            st_reg   <= '0;
            frac_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            st_reg   <= st_next;
            frac_reg <= frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // ------------------------------------------------------------------
    // Stage 0: line setup (dot product and squared length)
    // ------------------------------------------------------------------
    stg_t s0_next;
    logic signed [CW:0]   ldx, ldy, lrx, lry;
    logic signed [NQ-1:0] num;
    logic [DV-1:0]        den;

    always_comb
    begin
        ldx = $signed({iss.p1x[CW-1], iss.p1x}) - $signed({iss.p0x[CW-1], iss.p0x});
        ldy = $signed({iss.p1y[CW-1], iss.p1y}) - $signed({iss.p0y[CW-1], iss.p0y});
        lrx = $signed({iss.rx[CW-1], iss.rx}) - $signed({iss.p0x[CW-1], iss.p0x});
        lry = $signed({iss.ry[CW-1], iss.ry}) - $signed({iss.p0y[CW-1], iss.p0y});
        num = NQ'(lrx) * NQ'(ldx) + NQ'(lry) * NQ'(ldy);
        den = DV'($unsigned(NQ'(ldx) * NQ'(ldx) + NQ'(ldy) * NQ'(ldy)));
        s0_next = iss;
        s0_next.den = den;
        s0_next.rem = DV'($unsigned(num));
        s0_next.sat_zero = (den == '0) || (num <= 0);
        s0_next.sat_one  = !s0_next.sat_zero && (DV'($unsigned(num)) >= den);
        s0_next.q = '0;
    end

    // ------------------------------------------------------------------
    // Divider stages: one quotient bit per stage for the line parameter
    // ------------------------------------------------------------------
    stg_t dv_reg [FW+1];
    stg_t dv_next [FW];

    always_comb
    begin
        for (int k = 0; k < FW; k++)
        begin
            logic [DV-1:0] r2;
            dv_next[k] = dv_reg[k];
            r2 = {dv_reg[k].rem[DV-2:0], 1'b0};
            dv_next[k].q = {dv_reg[k].q[FW-2:0], 1'b0};
            if (r2 >= dv_reg[k].den)
            begin
                r2 = r2 - dv_reg[k].den;
                dv_next[k].q[0] = 1'b1;
            end
            dv_next[k].rem = r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FW; k++)
                dv_reg[k] <= '0;
        end
        else if (adv)
        begin
            dv_reg[0] <= s0_next;
            for (int k = 0; k < FW; k++)
                dv_reg[k+1] <= dv_next[k];
        end
    end

    // resolved parameter for lines, sample parameter otherwise
    stg_t e0;
    always_comb
    begin
        e0 = dv_reg[FW];
        if (e0.kind == ccpq_pkg::KIND_LINE)
        begin
            if (e0.sat_zero)
                e0.t = '0;
            else if (e0.sat_one)
                e0.t = PW'(1) << FW;
            else
                e0.t = {1'b0, e0.q};
        end
    end

    // ------------------------------------------------------------------
    // de Casteljau: three lerp levels, one register each
    // ------------------------------------------------------------------
    stg_t l1_reg, l2_reg, l3_reg;
    stg_t l1_next, l2_next, l3_next;

    always_comb
    begin
        l1_next = e0;
        l1_next.p0x = ccpq_pkg::lerp(e0.p0x, e0.p1x, e0.t);
        l1_next.p0y = ccpq_pkg::lerp(e0.p0y, e0.p1y, e0.t);
        l1_next.p1x = ccpq_pkg::lerp(e0.p1x, e0.p2x, e0.t);
        l1_next.p1y = ccpq_pkg::lerp(e0.p1y, e0.p2y, e0.t);
        l1_next.p2x = ccpq_pkg::lerp(e0.p2x, e0.p3x, e0.t);
        l1_next.p2y = ccpq_pkg::lerp(e0.p2y, e0.p3y, e0.t);
        // point, line and invalid answers are final after this level
        l1_next.p3x = e0.p0x;
        l1_next.p3y = e0.p0y;
        unique case (e0.kind)
            ccpq_pkg::KIND_POINT:
            begin
                l1_next.p3x = e0.p0x;
                l1_next.p3y = e0.p0y;
            end
            ccpq_pkg::KIND_LINE:
            begin
                l1_next.p3x = l1_next.p0x;
                l1_next.p3y = l1_next.p0y;
            end
            ccpq_pkg::KIND_CUBIC:
            begin
                l1_next.p3x = e0.p0x;
                l1_next.p3y = e0.p0y;
            end
            default:
            begin
                l1_next.p3x = '0;
                l1_next.p3y = '0;
            end
        endcase

        l2_next = l1_reg;
        l2_next.p0x = ccpq_pkg::lerp(l1_reg.p0x, l1_reg.p1x, l1_reg.t);
        l2_next.p0y = ccpq_pkg::lerp(l1_reg.p0y, l1_reg.p1y, l1_reg.t);
        l2_next.p1x = ccpq_pkg::lerp(l1_reg.p1x, l1_reg.p2x, l1_reg.t);
        l2_next.p1y = ccpq_pkg::lerp(l1_reg.p1y, l1_reg.p2y, l1_reg.t);

        l3_next = l2_reg;
        if (l2_reg.kind == ccpq_pkg::KIND_CUBIC)
        begin
            l3_next.p3x = ccpq_pkg::lerp(l2_reg.p0x, l2_reg.p1x, l2_reg.t);
            l3_next.p3y = ccpq_pkg::lerp(l2_reg.p0y, l2_reg.p1y, l2_reg.t);
        end
    end

    // ------------------------------------------------------------------
    // Squared distance, then running minimum
    // ------------------------------------------------------------------
    logic                 dq_vld_reg;
    stg_t                 dq_reg;
    logic [DW-1:0]        dq_d_reg, d_next;
    logic signed [CW:0]   ex, ey;

    always_comb
    begin
        ex = $signed({l3_reg.p3x[CW-1], l3_reg.p3x}) - $signed({l3_reg.rx[CW-1], l3_reg.rx});
        ey = $signed({l3_reg.p3y[CW-1], l3_reg.p3y}) - $signed({l3_reg.ry[CW-1], l3_reg.ry});
        d_next = $unsigned(DW'(ex) * DW'(ex)) + $unsigned(DW'(ey) * DW'(ey));
    end

    logic [DW-1:0]               bd_reg;
    logic [PW-1:0]               bt_reg;
    logic signed [NW-1:0]        bx_reg, by_reg;
    logic                        upd;
    assign upd = dq_reg.first || (dq_d_reg < bd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg     <= '0;
            l2_reg     <= '0;
            l3_reg     <= '0;
            dq_reg     <= '0;
            dq_d_reg   <= '0;
            dq_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
            bd_reg     <= '0;
            bt_reg     <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
        end
        else if (adv)
        begin
            l1_reg     <= l1_next;
            l2_reg     <= l2_next;
            l3_reg     <= l3_next;
            dq_reg     <= l3_reg;
            dq_d_reg   <= d_next;
            dq_vld_reg <= l3_reg.vld;
            out_valid  <= dq_vld_reg && dq_reg.last;
            if (dq_vld_reg && upd)
            begin
                bd_reg <= dq_d_reg;
                bt_reg <= dq_reg.t;
                bx_reg <= dq_reg.p3x;
                by_reg <= dq_reg.p3y;
            end
        end
    end

    // final result: winner including the last sample
    always_ff @(posedge clk)
    begin
        if (adv && dq_vld_reg && dq_reg.last)
        begin
            best_param <= upd ? dq_reg.t   : bt_reg;
            near_x     <= upd ? dq_reg.p3x : bx_reg;
            near_y     <= upd ? dq_reg.p3y : by_reg;
        end
    end

    `CCPQ_ASSERT_IMP(a_param_range, clk, rst_n, out_valid,
        best_param <= (PW'(1) << FW))
    `CCPQ_ASSERT_IMP(a_no_take_busy, clk, rst_n, busy_reg, in_stall)
    `CCPQ_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(best_param))
endmodule

/* tb/tb_curve_closest_point_query_core.sv */
// ----------------------------------------------------------------------------
// tb_curve_closest_point_query_core
// Drives point, line, cubic and invalid curve requests through the closest-
// point query core with random bursts and output stalls, predicts each
// result in the bench and compares best_param and near point field by field.
// ----------------------------------------------------------------------------
module tb_curve_closest_point_query_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef ccpq_pkg::kind_t  kind_t;
    typedef ccpq_pkg::coord_t coord_t;
    typedef ccpq_pkg::param_t param_t;

    localparam int     N_RAND    = 450;
    localparam int     FW        = ccpq_pkg::FRAC_W;
    localparam int     NSAMP     = ccpq_pkg::SAMPLES;
    localparam longint ONE_T     = 64'sd1 << FW;
    localparam int     CYC_LIMIT = 400000;

    typedef struct packed {
        kind_t  kind;
        coord_t ax, ay, bx, by, cx, cy, dx, dy, rx, ry;
    } query_t;

    typedef struct packed {
        param_t t;
        coord_t x, y;
    } answer_t;

    logic   clk, rst_n;
    logic   in_valid, in_stall, out_valid, out_stall;
    logic [1:0] curve_kind;
    coord_t first_x, first_y, second_x, second_y, third_x, third_y;
    coord_t fourth_x, fourth_y, ref_x, ref_y;
    param_t best_param;
    coord_t near_x, near_y;

    query_t  pending_q[$];
    answer_t answer_q[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      n_sent = 0, n_seen = 0, n_cubic = 0, n_line = 0;
    bit      feeding_done = 0;
    int      burst_left = 0, gap_left = 0;

    curve_closest_point_query_core DUT (.*);

    // Clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Rounded lerp, floor semantics on the shift
    function automatic longint mix(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t + (ONE_T >>> 1);
        return a + (p >>> FW);
    endfunction

    function automatic longint sq(longint v);
        return v * v;
    endfunction

    // Expected nearest parameter and point for one request
    function automatic answer_t nearest_answer(query_t q);
        answer_t r;
        longint  px[4], py[4], ex, ey, fx, fy, gx, gy, hx, hy, kx, ky, sx, sy;
        longint  t, lt, bt, bd, d, num, den, ddx, ddy;
        px[0] = q.ax; py[0] = q.ay; px[1] = q.bx; py[1] = q.by;
        px[2] = q.cx; py[2] = q.cy; px[3] = q.dx; py[3] = q.dy;
        r = '0;
        case (q.kind)
            ccpq_pkg::KIND_POINT:
            begin
                r.x = q.ax; r.y = q.ay;
            end
            ccpq_pkg::KIND_LINE:
            begin
                ddx = px[1] - px[0]; ddy = py[1] - py[0];
                den = sq(ddx) + sq(ddy);
                num = (longint'(q.rx) - px[0]) * ddx + (longint'(q.ry) - py[0]) * ddy;
                if (den == 0 || num <= 0) lt = 0;
                else if (num >= den) lt = ONE_T;
                else lt = (num << FW) / den;
                r.t = param_t'(lt);
                r.x = coord_t'(mix(px[0], px[1], lt));
                r.y = coord_t'(mix(py[0], py[1], lt));
            end
            ccpq_pkg::KIND_CUBIC:
            begin
                bd = 0; bt = 0; sx = px[0]; sy = py[0];
                for (int i = 0; i <= NSAMP; i++)
                begin
                    t  = ((longint'(i) << FW) + NSAMP / 2) / NSAMP;
                    ex = mix(px[0], px[1], t); ey = mix(py[0], py[1], t);
                    fx = mix(px[1], px[2], t); fy = mix(py[1], py[2], t);
                    gx = mix(px[2], px[3], t); gy = mix(py[2], py[3], t);
                    hx = mix(ex, fx, t);       hy = mix(ey, fy, t);
                    kx = mix(fx, gx, t);       ky = mix(fy, gy, t);
                    ex = mix(hx, kx, t);       ey = mix(hy, ky, t);
                    d  = sq(ex - q.rx) + sq(ey - q.ry);
                    if (i == 0 || d < bd)
                    begin
                        bd = d; bt = t; sx = ex; sy = ey;
                    end
                end
                r.t = param_t'(bt); r.x = coord_t'(sx); r.y = coord_t'(sy);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
            default: return coord_t'($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic query_t rnd_query();
        query_t q;
        int     m;
        m = ($urandom_range(0, 9) < 6) ? 1 : (($urandom_range(0, 4) == 0) ? 2 : 0);
        q.kind = kind_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0 && q.kind == ccpq_pkg::KIND_POINT)
            q.kind = ccpq_pkg::KIND_CUBIC;
        q.ax = rnd_coord(m); q.ay = rnd_coord(m); q.bx = rnd_coord(m); q.by = rnd_coord(m);
        q.cx = rnd_coord(m); q.cy = rnd_coord(m); q.dx = rnd_coord(m); q.dy = rnd_coord(m);
        q.rx = rnd_coord(m); q.ry = rnd_coord(m);
        // occasional degenerate line
        if (q.kind == ccpq_pkg::KIND_LINE && $urandom_range(0, 9) == 0)
        begin
            q.bx = q.ax; q.by = q.ay;
        end
        return q;
    endfunction

    function automatic query_t mk(kind_t k, int ax, int ay, int bx, int by,
                                  int cx, int cy, int dx, int dy, int rx, int ry);
        query_t q;
        q.kind = k;
        q.ax = coord_t'(ax); q.ay = coord_t'(ay);
        q.bx = coord_t'(bx); q.by = coord_t'(by);
        q.cx = coord_t'(cx); q.cy = coord_t'(cy);
        q.dx = coord_t'(dx); q.dy = coord_t'(dy);
        q.rx = coord_t'(rx); q.ry = coord_t'(ry);
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d", n_seen, what, got, want);
        mismatches++;
    endtask

    // Request driver: bursts and gaps, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            curve_kind <= '0;
            first_x  <= '0; first_y  <= '0;
            second_x <= '0; second_y <= '0;
            third_x  <= '0; third_y  <= '0;
            fourth_x <= '0; fourth_y <= '0;
            ref_x    <= '0; ref_y    <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (pending_q.size() > 0 && burst_left > 0)
            begin
                query_t q;
                q = pending_q.pop_front();
                answer_q.push_back(nearest_answer(q));
                n_sent++;
                if (q.kind == ccpq_pkg::KIND_CUBIC) n_cubic++;
                if (q.kind == ccpq_pkg::KIND_LINE) n_line++;
                burst_left--;
                in_valid   <= 1'b1;
                curve_kind <= q.kind;
                first_x  <= q.ax; first_y  <= q.ay;
                second_x <= q.bx; second_y <= q.by;
                third_x  <= q.cx; third_y  <= q.cy;
                fourth_x <= q.dx; fourth_y <= q.dy;
                ref_x    <= q.rx; ref_y    <= q.ry;
            end
            else
            begin
                in_valid <= 1'b0;
                if (burst_left == 0 && gap_left > 0) gap_left--;
            end
        end
    end

    // Result monitor and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cycles++;
            if (out_valid && !out_stall)
            begin
                answer_t w;
                if (answer_q.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", 1, 0);
                end
                else
                begin
                    w = answer_q.pop_front();
                    if (best_param !== w.t) report_mismatch("best_param", best_param, w.t);
                    if (near_x !== w.x) report_mismatch("near_x", near_x, w.x);
                    if (near_y !== w.y) report_mismatch("near_y", near_y, w.y);
                end
                n_seen++;
            end
            // quiet stretches while bit 9 of the cycle count is clear, random stalls otherwise
            out_stall <= cycles[9] ? ($urandom_range(0, 3) == 0) : 1'b0;
        end
    end

    // Stimulus
    initial
    begin
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // directed: kinds, extremes, line clamps, zero-length line, cubic ties
        pending_q.push_back(mk(ccpq_pkg::KIND_POINT, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0, 0,
                               5, 5));
        pending_q.push_back(mk(ccpq_pkg::KIND_BAD, 100, 200, 300, 400, 1, 2, 3, 4, 5, 6));
        pending_q.push_back(mk(ccpq_pkg::KIND_BAD, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 10, 10, 10, 10, 0, 0, 0, 0, 50, 50));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 0, 0, 1000, 0, 0, 0, 0, 0, -500, 30));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 0, 0, 1000, 0, 0, 0, 0, 0, 2500, -30));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 0, 0, 1000, 0, 0, 0, 0, 0, 1000, 0));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 0, 0, 1000, 300, 0, 0, 0, 0, 333, 777));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                               0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(ccpq_pkg::KIND_LINE, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                               0, 0, 0, 0, 16'sh7fff, 16'sh7fff));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0, 7, 7));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 0, 0, 100, 0, 200, 0, 300, 0, 150, 0));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 0, 0, 0, 1000, 1000, 1000, 1000, 0,
                               500, -300));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                               16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                               16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                               16'sh8000, 16'sh7fff));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, -500, 0, 0, 800, 0, -800, 500, 0, 0, 0));
        pending_q.push_back(mk(ccpq_pkg::KIND_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0,
                               16'sh8000, 16'sh7fff));

        // let the directed part drain fully before random traffic
        wait (pending_q.size() == 0 && answer_q.size() == 0);

        for (int i = 0; i < N_RAND; i++)
        begin
            pending_q.push_back(rnd_query());
            if (i == N_RAND / 2)
            begin
                wait (pending_q.size() == 0 && answer_q.size() == 0);
            end
        end
        wait (pending_q.size() == 0);
        feeding_done = 1;
    end

    // End of run and watchdog
    initial
    begin
        @(posedge rst_n);
        while (!(feeding_done && answer_q.size() == 0) && cycles < CYC_LIMIT)
            @(posedge clk);
        if (cycles >= CYC_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     answer_q.size());
            $display("== FAIL ==");
        end
        else
        begin
            repeat (200) @(posedge clk);
            $display("covered %0d requests (%0d cubic, %0d line), %0d results checked",
                     n_sent, n_cubic, n_line, n_seen);
            if (mismatches == 0 && answer_q.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/ccpq_pkg.sv
rtl/curve_closest_point_query_core.sv
tb/tb_curve_closest_point_query_core.sv
